// ===== hdl/fte_pkg.sv =====
// ----------------------------------------------------------------------------
// fte_pkg
// Shared types, codes and fixed texts of the format template expander.
// ----------------------------------------------------------------------------
package fte_pkg;

    localparam int DIGITS = 20;
    localparam int VALUE_W = 64;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;

    localparam logic [95:0] STR_BADFORMAT = "$(badformat)";
    localparam logic [79:0] STR_MISSING   = "$(missing)";
    localparam logic [79:0] STR_BADTYPE   = "$(badtype)";

    typedef enum logic [1:0] {
        TXT_BADFORMAT,
        TXT_MISSING,
        TXT_BADTYPE
    } text_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CONV,
        ST_DIGIT,
        ST_TEXT
    } state_t;

    // Number of characters of a fixed text, minus one.
    function automatic logic [3:0] text_last(input text_kind_t kind);
        case (kind)
            TXT_BADFORMAT: text_last = 4'd11;
            TXT_MISSING:   text_last = 4'd9;
            TXT_BADTYPE:   text_last = 4'd9;
            default:       text_last = 4'd11;
        endcase
    endfunction

    // Character at position pos of a fixed text, first character at zero.
    function automatic logic [7:0] text_char(input text_kind_t kind, input logic [3:0] pos);
        logic [3:0] rev;
        rev = text_last(kind) - pos;
        case (kind)
            TXT_BADFORMAT: text_char = STR_BADFORMAT[rev * 8 +: 8];
            TXT_MISSING:   text_char = STR_MISSING[rev * 8 +: 8];
            TXT_BADTYPE:   text_char = STR_BADTYPE[rev * 8 +: 8];
            default:       text_char = CHAR_DOLLAR;
        endcase
    endfunction

endpackage

// ===== hdl/fte_ram.sv =====
// ----------------------------------------------------------------------------
// fte_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/fte_bcd.sv =====
// ----------------------------------------------------------------------------
// fte_bcd
// Binary to decimal converter, one shift-and-add-three step per cycle.
// ----------------------------------------------------------------------------
module fte_bcd (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [fte_pkg::VALUE_W-1:0]        bin,
    output logic                               done,
    output logic [fte_pkg::DIGITS*4-1:0]       bcd
);

    import fte_pkg::*;

    logic [VALUE_W-1:0]  bin_reg;
    logic [DIGITS*4-1:0] bcd_reg;
    logic [DIGITS*4-1:0] adj;
    logic [6:0]          cnt_reg;
    logic                busy_reg;

    // Each digit at five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                          : bcd_reg[i*4 +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'(VALUE_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= bin;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {adj[DIGITS*4-2:0], bin_reg[VALUE_W-1]};
        end
    end

    assign done = busy_reg && (cnt_reg == 7'd1);
    assign bcd  = bcd_reg;

endmodule

// ===== hdl/format_template_expander_top.sv =====
// ----------------------------------------------------------------------------
// format_template_expander_top
// Expands a byte template with up to nine numeric parameters.
// ----------------------------------------------------------------------------
// Usage: the input stream carries two kinds of beat. A load beat (operation
// zero) writes one parameter slot and the parameter count and gives no output.
// A template beat (operation one) carries one template byte; tlast marks the
// final byte of a message. The output stream carries expanded bytes; tuser
// marks the last byte caused by one input beat and tlast marks the final byte
// of the whole message.
// Sequencing: a load or a literal byte leaves the expander idle, ready for
// the next beat. "$$" takes two input beats and gives one byte. A fixed
// error text is sent one character at a time. A numeric parameter passes
// through the parameter memory read, the shift-and-add-three converter,
// then each of the twenty digit positions from the top (leading zeros are
// skipped without output). Input is not taken while an expansion is
// under way.
// Reset clears the parameter count, the escape state and the slot valid bits;
// a slot that was never loaded reads as non-numeric. When the receiver
// stalls, the pending byte is held in the output register and the expansion
// waits; input is taken again once the output register can accept a byte.
// ----------------------------------------------------------------------------
module format_template_expander_top #(
    parameter int MAX_PARAMS = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata fields from bit 0: operation[0], param_index[4:1],
    // param_is_number[5], param_value[69:6], param_count[73:70],
    // template_byte[81:74], zero fill[87:82].
    input  logic [87:0] s_tdata,
    input  logic        s_tlast,   // last_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata fields from bit 0: out_byte[7:0].
    output logic [7:0]  m_tdata,
    // tuser fields from bit 0: run_last[0].
    output logic [0:0]  m_tuser,
    output logic        m_tlast,   // message_end
    output logic        m_tvalid,
    input  logic        m_tready
);

    import fte_pkg::*;

    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    // Input fields.
    logic                op;
    logic [3:0]          pidx;
    logic                pnum;
    logic [VALUE_W-1:0]  pval;
    logic [3:0]          pcnt;
    logic [7:0]          tbyte;

    assign op    = s_tdata[0];
    assign pidx  = s_tdata[4:1];
    assign pnum  = s_tdata[5];
    assign pval  = s_tdata[69:6];
    assign pcnt  = s_tdata[73:70];
    assign tbyte = s_tdata[81:74];

    state_t              state_reg, state_next;
    logic                esc_reg, esc_next;
    logic [3:0]          count_reg, count_next;
    logic [MAX_PARAMS-1:0] valid_reg, valid_next;
    logic                last_reg, last_next;
    logic [3:0]          slot_reg, slot_next;
    text_kind_t          kind_reg, kind_next;
    logic [3:0]          pos_reg, pos_next;
    logic [4:0]          dig_reg, dig_next;
    logic                started_reg, started_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_run_reg, out_run_next;
    logic                out_end_reg, out_end_next;

    logic                slot_free;
    logic                accept;
    logic                ram_we;
    logic                ram_re;
    logic [VALUE_W:0]    ram_rdata;
    logic                conv_start;
    logic                conv_done;
    logic [DIGITS*4-1:0] bcd;
    logic [3:0]          digit;
    logic [3:0]          esc_slot;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign ram_we    = accept && !op && (pidx < 4'(MAX_PARAMS));
    assign esc_slot  = tbyte[3:0] - CHAR_ONE[3:0];
    assign digit     = bcd[dig_reg * 4 +: 4];

    // Parameter store: flag in the top bit, value below it.
    fte_ram #(
        .WIDTH (VALUE_W + 1),
        .DEPTH (MAX_PARAMS)
    ) u_params (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pidx[AW-1:0]),
        .wdata ({pnum, pval}),
        .re    (ram_re),
        .raddr (esc_slot[AW-1:0]),
        .rdata (ram_rdata)
    );

    fte_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .bin   (ram_rdata[VALUE_W-1:0]),
        .done  (conv_done),
        .bcd   (bcd)
    );

    always_comb
    begin
        state_next     = state_reg;
        esc_next       = esc_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        last_next      = last_reg;
        slot_next      = slot_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        dig_next       = dig_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_run_next   = out_run_reg;
        out_end_next   = out_end_reg;
        ram_re         = 1'b0;
        conv_start     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!op)
                    begin
                        if (pidx < 4'(MAX_PARAMS))
                        begin
                            valid_next[pidx[AW-1:0]] = 1'b1;
                        end
                        count_next = (pcnt > 4'(MAX_PARAMS)) ? 4'(MAX_PARAMS) : pcnt;
                    end
                    else
                    begin
                        last_next = s_tlast;
                        pos_next  = '0;
                        if (esc_reg)
                        begin
                            esc_next = 1'b0;
                            if (tbyte >= CHAR_ONE && tbyte <= CHAR_NINE)
                            begin
                                slot_next = esc_slot;
                                if (esc_slot >= count_reg)
                                begin
                                    kind_next  = TXT_MISSING;
                                    state_next = ST_TEXT;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    state_next = ST_READ;
                                end
                            end
                            else if (tbyte == CHAR_DOLLAR)
                            begin
                                out_valid_next = 1'b1;
                                out_byte_next  = CHAR_DOLLAR;
                                out_run_next   = 1'b1;
                                out_end_next   = s_tlast;
                            end
                            else
                            begin
                                kind_next  = TXT_BADFORMAT;
                                state_next = ST_TEXT;
                            end
                        end
                        else if (tbyte == CHAR_DOLLAR)
                        begin
                            if (s_tlast)
                            begin
                                kind_next  = TXT_BADFORMAT;
                                state_next = ST_TEXT;
                            end
                            else
                            begin
                                esc_next = 1'b1;
                            end
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = tbyte;
                            out_run_next   = 1'b1;
                            out_end_next   = s_tlast;
                        end
                    end
                end
            end

            ST_READ:
            begin
                if (valid_reg[slot_reg[AW-1:0]] && ram_rdata[VALUE_W])
                begin
                    conv_start = 1'b1;
                    state_next = ST_CONV;
                end
                else
                begin
                    kind_next  = TXT_BADTYPE;
                    state_next = ST_TEXT;
                end
            end

            ST_CONV:
            begin
                if (conv_done)
                begin
                    dig_next     = 5'(DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = ST_DIGIT;
                end
            end

            ST_DIGIT:
            begin
                if (!started_reg && digit == 4'd0 && dig_reg != 5'd0)
                begin
                    dig_next = dig_reg - 5'd1;
                end
                else if (slot_free)
                begin
                    started_next   = 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = CHAR_ZERO | {4'd0, digit};
                    out_run_next   = (dig_reg == 5'd0);
                    out_end_next   = (dig_reg == 5'd0) && last_reg;
                    if (dig_reg == 5'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dig_next = dig_reg - 5'd1;
                    end
                end
            end

            ST_TEXT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = text_char(kind_reg, pos_reg);
                    out_run_next   = (pos_reg == text_last(kind_reg));
                    out_end_next   = (pos_reg == text_last(kind_reg)) && last_reg;
                    pos_next       = pos_reg + 4'd1;
                    if (pos_reg == text_last(kind_reg))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            esc_reg       <= 1'b0;
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            esc_reg       <= esc_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        slot_reg     <= slot_next;
        kind_reg     <= kind_next;
        pos_reg      <= pos_next;
        dig_reg      <= dig_next;
        started_reg  <= started_next;
        out_byte_reg <= out_byte_next;
        out_run_reg  <= out_run_next;
        out_end_reg  <= out_end_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tuser[0] = out_run_reg;
    assign m_tlast    = out_end_reg;

endmodule
